// ===== src/date_offset_by_days_unit_assert.svh =====
// Assertion macros for the date offset unit.
`ifndef DATE_OFFSET_BY_DAYS_UNIT_ASSERT_SVH
`define DATE_OFFSET_BY_DAYS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define DOBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dobd assertion failed");
`define DOBD_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("dobd forbidden condition seen");
`else
`define DOBD_ASSERT(lbl, prop)
`define DOBD_NEVER(lbl, prop)
`endif

`endif

// ===== src/dobd_pkg.sv =====
// Shared constants, types and functions of the date offset unit.
`timescale 1ns / 1ps
`default_nettype none

package dobd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int YEAR_IN_W   = 14;
  localparam int MONTH_W     = 4;
  localparam int DAY_IN_W    = 5;
  localparam int YEAR_W      = 18;
  localparam int D_W         = ((COUNT_WIDTH > 17) ? COUNT_WIDTH : 17) + 2;
  localparam int REM_W       = 9;
  localparam int RED_STEPS   = 6;
  localparam int RED_CNT_W   = 3;

  localparam int CYCLE_DAYS  = 146097;
  localparam int CYCLE_YEARS = 400;
  localparam int YEAR_MAX    = 9999;

  localparam logic [MONTH_W-1:0] JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DEC = MONTH_W'(12);

  typedef struct packed {
    logic load;
    logic reduce;
    logic cyc_step;
    logic month_step;
    logic capture;
  } dp_cmd_t;

  typedef struct packed {
    logic red_last;
    logic cyc_need;
    logic month_need;
  } dp_sts_t;

  // leap test on year mod 400
  function automatic logic is_leap(input logic [REM_W-1:0] r);
    logic cent;
    cent = (r == REM_W'(0)) || (r == REM_W'(100)) || (r == REM_W'(200)) ||
           (r == REM_W'(300));
    return ((r[1:0] == 2'd0) && !cent) || (r == REM_W'(0));
  endfunction

  function automatic logic [DAY_IN_W-1:0] month_len(input logic leap,
                                                    input logic [MONTH_W-1:0] m);
    logic [DAY_IN_W-1:0] len;
    case (m)
      FEB:                       len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== src/date_offset_by_days_unit.sv =====
// Date offset unit: Gregorian date moved forward or back by a day count.
//
// Input channel: in_valid_i / in_stall_o carries one word (operation, start
// date, day count); it is taken when in_valid_i is high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carries the resulting date and an
// overflow flag; the word is taken when out_valid_o is high and out_stall_i low.
// One word in gives exactly one word out, in order.
// Steps: a load, the reduction of the year mod 400, a step per whole 400-year
// span, then a step per month crossed and the capture of the result; a
// 65535-day count crosses about 2153 months. The month stepper handles one
// month per cycle and one word at a time, so a new word is taken only after
// the last result has been captured.
// The input stalls while a word is being worked on. A finished result sits in
// the output register; the next word may be taken while it waits. If the
// receiver stalls and a second result is ready, the stepper holds it until the
// output register frees.
// Reset clears the controller and the output valid; no word is in flight after.
`timescale 1ns / 1ps
`default_nettype none
`include "date_offset_by_days_unit_assert.svh"

module date_offset_by_days_unit import dobd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   operation_i,
  input  logic [YEAR_IN_W-1:0]   start_year_i,
  input  logic [MONTH_W-1:0]     start_month_i,
  input  logic [DAY_IN_W-1:0]    start_day_i,
  input  logic [COUNT_WIDTH-1:0] day_count_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [YEAR_IN_W-1:0]   result_year_o,
  output logic [MONTH_W-1:0]     result_month_o,
  output logic [DAY_IN_W-1:0]    result_day_o,
  output logic                   year_overflow_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    res_zero;
  logic    month_ok;

  dobd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dobd_datapath u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .start_year_i    (start_year_i),
    .start_month_i   (start_month_i),
    .start_day_i     (start_day_i),
    .day_count_i     (day_count_i),
    .result_year_o   (result_year_o),
    .result_month_o  (result_month_o),
    .result_day_o    (result_day_o),
    .year_overflow_o (year_overflow_o)
  );

  assign res_zero = (result_year_o == '0) && (result_month_o == '0) && (result_day_o == '0);
  assign month_ok = (result_month_o >= JAN) && (result_month_o <= DEC);

  `DOBD_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `DOBD_ASSERT(a_ovf_zeroes, (out_valid_o && year_overflow_o) |-> res_zero)
  `DOBD_ASSERT(a_month_valid, (out_valid_o && !year_overflow_o) |-> month_ok)
  `DOBD_NEVER(a_capture_over_held, cmd.capture && out_valid_o && out_stall_i)

endmodule

`default_nettype wire

// ===== src/dobd_ctrl.sv =====
// Controller state machine of the date offset unit.
`timescale 1ns / 1ps
`default_nettype none

module dobd_ctrl import dobd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_CYCLE  = 3'd2;
  localparam logic [2:0] S_MONTH  = 3'd3;
  localparam logic [2:0] S_HOLD   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.reduce = 1'b1;
        if (sts_i.red_last) state_d = S_CYCLE;
      end
      S_CYCLE: begin
        if (sts_i.cyc_need) cmd_o.cyc_step = 1'b1;
        else state_d = S_MONTH;
      end
      S_MONTH: begin
        if (sts_i.month_need) begin
          cmd_o.month_step = 1'b1;
        end else if (out_free) begin
          cmd_o.capture = 1'b1;
          state_d       = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd_o.capture = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.capture) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== src/dobd_datapath.sv =====
// Datapath of the date offset unit: date registers, month stepper, result word.
`timescale 1ns / 1ps
`default_nettype none

module dobd_datapath import dobd_pkg::*; (
  input  logic                   clk_i,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  input  logic                   operation_i,
  input  logic [YEAR_IN_W-1:0]   start_year_i,
  input  logic [MONTH_W-1:0]     start_month_i,
  input  logic [DAY_IN_W-1:0]    start_day_i,
  input  logic [COUNT_WIDTH-1:0] day_count_i,
  output logic [YEAR_IN_W-1:0]   result_year_o,
  output logic [MONTH_W-1:0]     result_month_o,
  output logic [DAY_IN_W-1:0]    result_day_o,
  output logic                   year_overflow_o
);

  localparam logic signed [D_W-1:0]    CYC_D     = D_W'(CYCLE_DAYS);
  localparam logic signed [D_W-1:0]    NEG_CYC_D = -D_W'(CYCLE_DAYS);
  localparam logic signed [D_W-1:0]    D_ONE     = D_W'(1);
  localparam logic signed [YEAR_W-1:0] Y_CYC     = YEAR_W'(CYCLE_YEARS);
  localparam logic signed [YEAR_W-1:0] Y_ONE     = YEAR_W'(1);
  localparam logic signed [YEAR_W-1:0] Y_MAX     = YEAR_W'(YEAR_MAX);
  localparam logic [REM_W-1:0]         REM_TOP   = REM_W'(CYCLE_YEARS - 1);

  logic                     op_q;
  logic signed [YEAR_W-1:0] year_q;
  logic [MONTH_W-1:0]       month_q;
  logic signed [D_W-1:0]    day_q;
  logic [YEAR_IN_W-1:0]     rem_q;
  logic [RED_CNT_W-1:0]     red_cnt_q;
  logic [YEAR_IN_W-1:0]     res_year_q;
  logic [MONTH_W-1:0]       res_month_q;
  logic [DAY_IN_W-1:0]      res_day_q;
  logic                     res_ovf_q;

  logic [REM_W-1:0]         r400;
  logic                     leap;
  logic [MONTH_W-1:0]       prev_m;
  logic [DAY_IN_W-1:0]      fwd_len;
  logic [DAY_IN_W-1:0]      bwd_len;
  logic signed [D_W-1:0]    fwd_len_s;
  logic signed [D_W-1:0]    bwd_len_s;
  logic [YEAR_IN_W-1:0]     red_sub;
  logic signed [D_W-1:0]    sday;
  logic signed [D_W-1:0]    scount;
  logic [MONTH_W-1:0]       mclamp;
  logic                     ovf;

  assign r400      = rem_q[REM_W-1:0];
  assign leap      = is_leap(r400);
  assign prev_m    = (month_q == JAN) ? DEC : month_q - MONTH_W'(1);
  assign fwd_len   = month_len(leap, month_q);
  assign bwd_len   = month_len(leap, prev_m);
  assign fwd_len_s = $signed(D_W'(fwd_len));
  assign bwd_len_s = $signed(D_W'(bwd_len));
  assign red_sub   = YEAR_IN_W'(CYCLE_YEARS) << red_cnt_q;
  assign sday      = $signed(D_W'(start_day_i));
  assign scount    = $signed(D_W'(day_count_i));
  assign mclamp    = (start_month_i == MONTH_W'(0)) ? JAN :
                     (start_month_i > DEC) ? DEC : start_month_i;
  assign ovf       = (year_q < Y_ONE) || (year_q > Y_MAX);

  assign sts_o.red_last   = (red_cnt_q == RED_CNT_W'(0));
  assign sts_o.cyc_need   = op_q ? (day_q <= NEG_CYC_D) : (day_q > CYC_D);
  assign sts_o.month_need = op_q ? (day_q < D_ONE) : (day_q > fwd_len_s);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= operation_i;
      year_q    <= $signed(YEAR_W'(start_year_i));
      month_q   <= mclamp;
      day_q     <= operation_i ? (sday - scount) : (sday + scount);
      rem_q     <= start_year_i;
      red_cnt_q <= RED_CNT_W'(RED_STEPS - 1);
    end else if (cmd_i.reduce) begin
      if (rem_q >= red_sub) rem_q <= rem_q - red_sub;
      red_cnt_q <= red_cnt_q - RED_CNT_W'(1);
    end else if (cmd_i.cyc_step) begin
      if (op_q) begin
        day_q  <= day_q + CYC_D;
        year_q <= year_q - Y_CYC;
      end else begin
        day_q  <= day_q - CYC_D;
        year_q <= year_q + Y_CYC;
      end
    end else if (cmd_i.month_step) begin
      if (op_q) begin
        // February never wraps the year, so the current leap flag serves
        day_q   <= day_q + bwd_len_s;
        month_q <= prev_m;
        if (month_q == JAN) begin
          year_q <= year_q - Y_ONE;
          rem_q  <= YEAR_IN_W'((r400 == REM_W'(0)) ? REM_TOP : r400 - REM_W'(1));
        end
      end else begin
        day_q <= day_q - fwd_len_s;
        if (month_q == DEC) begin
          month_q <= JAN;
          year_q  <= year_q + Y_ONE;
          rem_q   <= YEAR_IN_W'((r400 == REM_TOP) ? REM_W'(0) : r400 + REM_W'(1));
        end else begin
          month_q <= month_q + MONTH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_ovf_q   <= ovf;
      res_year_q  <= ovf ? '0 : year_q[YEAR_IN_W-1:0];
      res_month_q <= ovf ? '0 : month_q;
      res_day_q   <= ovf ? '0 : day_q[DAY_IN_W-1:0];
    end
  end

  assign result_year_o   = res_year_q;
  assign result_month_o  = res_month_q;
  assign result_day_o    = res_day_q;
  assign year_overflow_o = res_ovf_q;

endmodule

`default_nettype wire

// ===== dv/date_offset_by_days_checker.sv =====
// Direction codes and the scoreboard that predicts and checks the date offset unit.
`timescale 1ns / 1ps

package dobd_dir_pkg;
  localparam logic DIR_LATER   = 1'b0;
  localparam logic DIR_EARLIER = 1'b1;
endpackage

module date_offset_by_days_checker import dobd_pkg::*; import dobd_dir_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic                   operation_i,
  input  logic [YEAR_IN_W-1:0]   start_year_i,
  input  logic [MONTH_W-1:0]     start_month_i,
  input  logic [DAY_IN_W-1:0]    start_day_i,
  input  logic [COUNT_WIDTH-1:0] day_count_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [YEAR_IN_W-1:0]   result_year_i,
  input  logic [MONTH_W-1:0]     result_month_i,
  input  logic [DAY_IN_W-1:0]    result_day_i,
  input  logic                   year_overflow_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [YEAR_IN_W-1:0] year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_IN_W-1:0]  day;
    logic                 ovf;
  } date_word_t;

  date_word_t expected_dates[$];
  int         fails = 0;
  int         pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic int days_in_month(input int y, input int m);
    logic leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic date_word_t shift_date(input logic                   dir,
                                            input logic [YEAR_IN_W-1:0]   y_in,
                                            input logic [MONTH_W-1:0]     m_in,
                                            input logic [DAY_IN_W-1:0]    d_in,
                                            input logic [COUNT_WIDTH-1:0] cnt);
    int         y;
    int         m;
    int         d;
    date_word_t w;
    y = int'(y_in);
    m = int'(m_in);
    d = int'(d_in);
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (dir == DIR_LATER) begin
      d = d + int'(cnt);
      while (d > CYCLE_DAYS) begin
        d -= CYCLE_DAYS;
        y += CYCLE_YEARS;
      end
      while (d > days_in_month(y, m)) begin
        d -= days_in_month(y, m);
        m++;
        if (m > 12) begin
          m = 1;
          y++;
        end
      end
    end else begin
      d = d - int'(cnt);
      while (d <= -CYCLE_DAYS) begin
        d += CYCLE_DAYS;
        y -= CYCLE_YEARS;
      end
      while (d < 1) begin
        m--;
        if (m < 1) begin
          m = 12;
          y--;
        end
        d += days_in_month(y, m);
      end
    end
    if (y < 1 || y > YEAR_MAX) begin
      w = '{year: '0, month: '0, day: '0, ovf: 1'b1};
    end else begin
      w.year  = y[YEAR_IN_W-1:0];
      w.month = m[MONTH_W-1:0];
      w.day   = d[DAY_IN_W-1:0];
      w.ovf   = 1'b0;
    end
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    date_word_t got;
    date_word_t want;
    if (!rst_ni) begin
      expected_dates.delete();
      pending <= 0;
    end else begin
      // retire first so a word taken this edge never matches itself
      if (out_valid_i && !out_stall_i) begin
        got = '{year: result_year_i, month: result_month_i, day: result_day_i,
                ovf: year_overflow_i};
        if (expected_dates.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected word y=%0d m=%0d d=%0d ovf=%0b", $realtime,
                     got.year, got.month, got.day, got.ovf);
          fails++;
        end else begin
          want = expected_dates.pop_front();
          if (got !== want) begin
            if (fails < 10)
              $display("%0t: mismatch exp y=%0d m=%0d d=%0d ovf=%0b got y=%0d m=%0d d=%0d ovf=%0b",
                       $realtime, want.year, want.month, want.day, want.ovf,
                       got.year, got.month, got.day, got.ovf);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_dates.push_back(shift_date(operation_i, start_year_i, start_month_i,
                                            start_day_i, day_count_i));
      pending <= expected_dates.size();
    end
  end

endmodule

// ===== dv/date_offset_by_days_unit_tb.sv =====
// Stimulus, receiver pacing and verdict for the date offset unit regression.
`timescale 1ns / 1ps

module date_offset_by_days_unit_tb import dobd_pkg::*; import dobd_dir_pkg::*;;

  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   operation = DIR_LATER;
  logic [YEAR_IN_W-1:0]   start_year = '0;
  logic [MONTH_W-1:0]     start_month = '0;
  logic [DAY_IN_W-1:0]    start_day = '0;
  logic [COUNT_WIDTH-1:0] day_count = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [YEAR_IN_W-1:0]   result_year;
  logic [MONTH_W-1:0]     result_month;
  logic [DAY_IN_W-1:0]    result_day;
  logic                   year_overflow;
  int                     fail_count;
  int                     pending;
  int                     hold_reqs = 0;
  int                     burst_left = 0;

  date_offset_by_days_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .start_year_i   (start_year),
    .start_month_i  (start_month),
    .start_day_i    (start_day),
    .day_count_i    (day_count),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_year_o  (result_year),
    .result_month_o (result_month),
    .result_day_o   (result_day),
    .year_overflow_o(year_overflow)
  );

  date_offset_by_days_checker scoreboard (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .operation_i    (operation),
    .start_year_i   (start_year),
    .start_month_i  (start_month),
    .start_day_i    (start_day),
    .day_count_i    (day_count),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .result_year_i  (result_year),
    .result_month_i (result_month),
    .result_day_i   (result_day),
    .year_overflow_i(year_overflow),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("date_offset_by_days_unit regression: fail");
    $finish;
  end

  task automatic offer_word(input logic dir, input int y, input int m, input int d,
                            input int cnt);
    in_valid    <= 1'b1;
    operation   <= dir;
    start_year  <= YEAR_IN_W'(y);
    start_month <= MONTH_W'(m);
    start_day   <= DAY_IN_W'(d);
    day_count   <= COUNT_WIDTH'(cnt);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic paced_word(input logic dir, input int y, input int m, input int d,
                            input int cnt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    offer_word(dir, y, m, d, cnt);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_word();
    logic dir;
    int   y;
    int   m;
    int   d;
    int   cnt;
    int   pick;
    dir = ($urandom_range(0, 1) == 0) ? DIR_LATER : DIR_EARLIER;
    if ($urandom_range(0, 99) < 80) begin
      y = $urandom_range(1, 9999);
      if ($urandom_range(0, 9) == 0)
        y = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(9997, 9999);
      m = $urandom_range(1, 12);
      d = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 28) : $urandom_range(29, 31);
    end else begin
      y = $urandom_range(0, 16383);
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end
    pick = $urandom_range(0, 9);
    if (pick < 6)
      cnt = $urandom_range(0, 400);
    else if (pick < 8)
      cnt = $urandom_range(0, 4000);
    else if (pick == 8)
      cnt = $urandom_range(0, 65535);
    else
      cnt = ($urandom_range(0, 2) == 0) ? 0 : 65535 - $urandom_range(0, 50);
    paced_word(dir, y, m, d, cnt);
  endtask

  // receiver: random stall modes, plus a long hold-off on request
  initial begin
    rx_mode_e mode;
    int       left;
    int       holds_done;
    mode = RX_FREE;
    left = 0;
    holds_done = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_done++;
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ~out_stall;
        endcase
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    paced_word(DIR_LATER,   2024,  2, 28, 1);
    paced_word(DIR_LATER,   1900,  2, 28, 1);
    paced_word(DIR_LATER,   2000,  2, 28, 1);
    paced_word(DIR_LATER,   2023, 12, 31, 1);
    paced_word(DIR_EARLIER, 2023,  3,  1, 1);
    paced_word(DIR_EARLIER, 2024,  1,  1, 1);
    paced_word(DIR_LATER,   9999, 12, 31, 1);
    paced_word(DIR_EARLIER,    1,  1,  1, 1);
    paced_word(DIR_LATER,      1,  1,  1, 0);
    paced_word(DIR_LATER,      1,  1,  1, 65535);
    paced_word(DIR_EARLIER, 9999, 12, 31, 65535);
    paced_word(DIR_LATER,   2001,  0, 15, 20);
    paced_word(DIR_LATER,   2001, 13, 10, 30);
    paced_word(DIR_EARLIER, 2001, 15,  5, 3);
    paced_word(DIR_LATER,      0, 12, 31, 1);
    paced_word(DIR_EARLIER,    0,  6,  1, 0);
    paced_word(DIR_LATER,  16383,  1,  1, 0);
    paced_word(DIR_EARLIER, 10000, 1,  1, 1);
    paced_word(DIR_LATER,   2023,  2, 31, 0);
    paced_word(DIR_EARLIER, 2023,  4, 31, 0);
    paced_word(DIR_LATER,   2023,  5,  0, 0);
    paced_word(DIR_EARLIER, 2023,  5,  0, 0);
    paced_word(DIR_EARLIER, 2023,  1,  0, 0);
    paced_word(DIR_LATER,   2023,  4, 31, 0);

    wait_drained();

    // receiver holds off while words keep coming so the unit backs up
    hold_reqs <= hold_reqs + 1;
    for (int k = 0; k < 6; k++)
      offer_word(($urandom_range(0, 1) == 0) ? DIR_LATER : DIR_EARLIER,
                 $urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 28),
                 $urandom_range(0, 60));

    for (int i = 0; i < 250; i++) begin
      if (i == 120) wait_drained();
      random_word();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("date_offset_by_days_unit regression: pass");
    end else begin
      $display("date_offset_by_days_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/dobd_pkg.sv
src/dobd_ctrl.sv
src/dobd_datapath.sv
src/date_offset_by_days_unit.sv
dv/date_offset_by_days_checker.sv
dv/date_offset_by_days_unit_tb.sv
